[rtl/core/scaled_softmax_row_core_assert.svh]
// Assertion macros shared by the checker of the softmax row core.
`ifndef SCALED_SOFTMAX_ROW_CORE_ASSERT_SVH
`define SCALED_SOFTMAX_ROW_CORE_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define SSR_ASSERT_SAME(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("softmax row core assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("softmax row core assertion failed");
`endif

[rtl/core/ssr_pkg.sv]
`default_nettype none
package ssr_pkg;

	localparam int MAX_ROW = 4096;
	localparam int ADDR_W = $clog2(MAX_ROW);
	localparam int LEN_W = ADDR_W + 1;
	localparam int Q_W = 24;
	localparam int EXP_TABLE_SIZE = 256;
	localparam int EXP_IDX_W = $clog2(EXP_TABLE_SIZE);
	localparam int IDX_SHIFT = 16 - EXP_IDX_W;
	localparam int EXP_W = 25;
	localparam int T_PROD_W = 49;
	localparam int SUM_W = 37;
	localparam int INV_W = 32;
	localparam int P_W = EXP_W + INV_W;
	localparam int DIV_STEPS = 56;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
	localparam longint unsigned LN2_Q30 = 64'd744261118;
	localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
	localparam logic [Q_W-1:0] Q816_MAX = 24'h7FFFFF;
	localparam logic [Q_W-1:0] Q816_MIN = 24'h800000;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_READY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic capture;
		logic load;
		logic start_sum;
		logic addr_pos;
		logic [ADDR_W-1:0] sum_addr;
		logic acc;
		logic div_init;
		logic div_step;
		logic div_bit;
		logic div_fin;
		logic pmul;
		logic norm_init;
		logic norm_coarse;
		logic norm_fine;
		logic res_zero;
		logic out_load;
		logic [1:0] out_status;
	} ssr_cmd_t;

	typedef struct packed {
		logic kind;
		logic last;
		logic ready;
		logic ovf;
		logic pos_ok;
		logic [LEN_W-1:0] len;
		logic top_zero;
		logic p_zero;
	} ssr_stat_t;

	// Round to nearest, ties to even, of x shifted right by sh bits.
	function automatic logic [63:0] rne_shift(input logic [63:0] x, input logic [6:0] sh);
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		if (sh == 7'd0) begin
			return x;
		end
		if (sh > 7'd63) begin
			return 64'd0;
		end
		q = x >> sh;
		rem = x & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 7'd1);
		if (rem > half || (rem == half && q[0])) begin
			q = q + 64'd1;
		end
		return q;
	endfunction

	// Integer quotient of a by a small divisor, by restoring long division.
	function automatic logic [63:0] small_div(input logic [63:0] a, input logic [4:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= {59'd0, d}) begin
				r = r - {59'd0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// bf16 score divided by 16, as saturated signed Q8.16.
	function automatic logic [Q_W-1:0] bf16_to_q816(input logic [15:0] b);
		logic neg;
		logic [7:0] ex;
		logic [63:0] sig;
		logic [63:0] mag;
		int k;
		logic [Q_W-1:0] r;
		neg = b[15];
		ex = b[14:7];
		sig = {56'd0, 1'b1, b[6:0]};
		k = int'(ex) - 122;
		mag = 64'd0;
		r = '0;
		if (ex == 8'd0) begin
			r = '0;
		end else if (ex == 8'hFF) begin
			if (b[6:0] != 7'd0) r = '0;
			else r = neg ? Q816_MIN : Q816_MAX;
		end else begin
			if (k > 16) mag = 64'd1 << 24;
			else if (k >= 0) mag = sig << k;
			else if (-k > 12) mag = 64'd0;
			else mag = rne_shift(sig, 7'(-k));
			if (neg) begin
				if (mag > 64'd8388608) mag = 64'd8388608;
				r = Q_W'(64'd0 - mag);
			end else begin
				if (mag > 64'(Q816_MAX)) mag = 64'(Q816_MAX);
				r = mag[Q_W-1:0];
			end
		end
		return r;
	endfunction

	// Entry k holds 2^(-k/size) in Q1.24, from a truncated series of exp(-x).
	function automatic logic [EXP_TABLE_SIZE-1:0][EXP_W-1:0] build_exp_table();
		logic [EXP_TABLE_SIZE-1:0][EXP_W-1:0] tb;
		longint unsigned x;
		longint unsigned term;
		longint s;
		logic [63:0] rs;
		for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
			x = (longint'(k) * LN2_Q30 + (64'd1 << (EXP_IDX_W - 1))) >> EXP_IDX_W;
			term = 64'd1 << 30;
			s = 64'sd1 <<< 30;
			for (int n = 1; n <= 20; n++) begin
				term = small_div((term * x) >> 30, 5'(n));
				if ((n & 1) == 1) s = s - longint'(term);
				else s = s + longint'(term);
			end
			if (s < 0) s = 0;
			rs = rne_shift(64'(s), 7'd6);
			tb[k] = rs[EXP_W-1:0];
		end
		return tb;
	endfunction

	localparam logic [EXP_TABLE_SIZE-1:0][EXP_W-1:0] EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

[rtl/core/ssr_datapath.sv]
`default_nettype none
module ssr_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                kind,
	input  wire logic [15:0]         score_bits,
	input  wire logic                last,
	input  wire logic [11:0]         position,
	input  wire ssr_pkg::ssr_cmd_t   cmd,
	output ssr_pkg::ssr_stat_t       stat,
	output logic [15:0]              probability_bits,
	output logic [1:0]               status
);

	logic [ssr_pkg::Q_W-1:0] mem [ssr_pkg::MAX_ROW];

	logic kind_q;
	logic last_q;
	logic [ssr_pkg::ADDR_W-1:0] pos_q;
	logic [ssr_pkg::Q_W-1:0] s_q;

	logic [ssr_pkg::LEN_W-1:0] len_q;
	logic [ssr_pkg::Q_W-1:0] max_q;
	logic [ssr_pkg::INV_W-1:0] inv_q;
	logic ready_q;
	logic ovf_q;
	logic [ssr_pkg::SUM_W-1:0] sum_q;

	logic [ssr_pkg::Q_W-1:0] rdata_s1;
	logic [ssr_pkg::T_PROD_W-1:0] prod_s2;
	logic [9:0] n_s3;
	logic [ssr_pkg::EXP_IDX_W-1:0] idx_s3;
	logic [ssr_pkg::EXP_W-1:0] exp_s4;
	logic [ssr_pkg::P_W-1:0] p_s5;

	logic [ssr_pkg::SUM_W-1:0] rem_q;
	logic [ssr_pkg::INV_W-1:0] quo_q;

	logic [63:0] nrm_q;
	logic [5:0] b_q;
	logic [15:0] res_q;

	logic [ssr_pkg::LEN_W-1:0] len_e;
	logic [ssr_pkg::Q_W-1:0] max_e;
	logic ovf_e;
	logic full;
	logic we;
	logic [ssr_pkg::ADDR_W-1:0] rd_addr;

	logic [24:0] diff;
	logic [23:0] t_val;
	logic [63:0] w_val;
	logic [63:0] idx_r;
	logic [9:0] n_val;
	logic [63:0] exp_r;

	logic [37:0] rem_sh;
	logic rem_ge;
	logic [37:0] rem_sub;
	logic [37:0] acc_sum;
	logic inv_inc;

	logic [2:0] lz;
	logic [63:0] nrm_sh;
	logic rnd_inc;
	logic [8:0] mant9;
	logic [8:0] biased;
	logic [6:0] mant7;

	always_comb begin
		len_e = ready_q ? '0 : len_q;
		max_e = ready_q ? ssr_pkg::Q816_MIN : max_q;
		ovf_e = ready_q ? 1'b0 : ovf_q;
		full = (len_e == ssr_pkg::LEN_W'(ssr_pkg::MAX_ROW));
		we = cmd.load && !full;
		rd_addr = cmd.addr_pos ? pos_q : cmd.sum_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			last_q <= last;
			pos_q <= position;
			s_q <= ssr_pkg::bf16_to_q816(score_bits);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[len_e[ssr_pkg::ADDR_W-1:0]] <= s_q;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Exponential pipeline: distance from the maximum, base-2 scaling, table and shift.
	always_comb begin
		diff = {max_q[23], max_q} - {rdata_s1[23], rdata_s1};
		t_val = diff[24] ? 24'd0 : diff[23:0];
		w_val = ssr_pkg::rne_shift({15'd0, prod_s2}, 7'd24);
		idx_r = ssr_pkg::rne_shift({48'd0, w_val[15:0]}, 7'(ssr_pkg::IDX_SHIFT));
		n_val = w_val[25:16];
		exp_r = ssr_pkg::rne_shift({39'd0, ssr_pkg::EXP_TABLE[idx_s3]}, {1'b0, n_s3[5:0]});
	end

	always_ff @(posedge clk) begin
		prod_s2 <= {25'd0, t_val} * {24'd0, ssr_pkg::LOG2E_Q24};
		if (idx_r[ssr_pkg::EXP_IDX_W]) begin
			idx_s3 <= '0;
			n_s3 <= n_val + 10'd1;
		end else begin
			idx_s3 <= idx_r[ssr_pkg::EXP_IDX_W-1:0];
			n_s3 <= n_val;
		end
		exp_s4 <= (n_s3 > 10'd40) ? '0 : exp_r[ssr_pkg::EXP_W-1:0];
		if (cmd.pmul) begin
			p_s5 <= {{(ssr_pkg::INV_W){1'b0}}, exp_s4} * {{(ssr_pkg::EXP_W){1'b0}}, inv_q};
		end
	end

	always_comb begin
		rem_sh = {rem_q, cmd.div_bit};
		rem_ge = rem_sh >= {1'b0, sum_q};
		rem_sub = rem_ge ? rem_sh - {1'b0, sum_q} : rem_sh;
		acc_sum = {1'b0, sum_q} + 38'(exp_s4);
		inv_inc = ({rem_q, 1'b0} > {1'b0, sum_q}) || (({rem_q, 1'b0} == {1'b0, sum_q}) && quo_q[0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_sub[ssr_pkg::SUM_W-1:0];
			quo_q <= {quo_q[ssr_pkg::INV_W-2:0], rem_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			max_q <= ssr_pkg::Q816_MIN;
			inv_q <= '0;
			ready_q <= 1'b0;
			ovf_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (cmd.load) begin
				len_q <= full ? len_e : len_e + 1'b1;
				max_q <= (!full && $signed(s_q) > $signed(max_e)) ? s_q : max_e;
				ovf_q <= ovf_e | full;
				ready_q <= 1'b0;
				if (ready_q) inv_q <= '0;
			end
			if (cmd.start_sum) begin
				sum_q <= '0;
			end else if (cmd.acc) begin
				sum_q <= (acc_sum > {1'b0, ssr_pkg::SUM_LIMIT}) ? ssr_pkg::SUM_LIMIT :
					acc_sum[ssr_pkg::SUM_W-1:0];
			end
			if (cmd.div_fin) begin
				inv_q <= (sum_q == '0) ? '0 : quo_q + ssr_pkg::INV_W'(inv_inc);
				ready_q <= 1'b1;
			end
		end
	end

	// Conversion to bf16: coarse byte shifts, then one in-byte shift with rounding.
	always_comb begin
		lz = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (nrm_q[56 + i]) lz = 3'(7 - i);
		end
		nrm_sh = nrm_q << lz;
		rnd_inc = nrm_sh[55] && ((nrm_sh[54:0] != '0) || nrm_sh[56]);
		mant9 = {1'b0, nrm_sh[63:56]} + 9'(rnd_inc);
		biased = 9'(b_q) - 9'(lz) + 9'd72 + 9'(mant9[8]);
		mant7 = mant9[8] ? 7'd0 : mant9[6:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.norm_init) begin
			nrm_q <= 64'(p_s5);
			b_q <= 6'd63;
		end else if (cmd.norm_coarse) begin
			nrm_q <= nrm_q << 8;
			b_q <= b_q - 6'd8;
		end
		if (cmd.res_zero) begin
			res_q <= '0;
		end else if (cmd.norm_fine) begin
			res_q <= {biased, mant7};
		end
		if (cmd.out_load) begin
			probability_bits <= res_q;
			status <= cmd.out_status;
		end
	end

	always_comb begin
		stat.kind = kind_q;
		stat.last = last_q;
		stat.ready = ready_q;
		stat.ovf = ovf_q;
		stat.pos_ok = {1'b0, pos_q} < len_q;
		stat.len = len_q;
		stat.top_zero = (nrm_q[63:56] == 8'd0);
		stat.p_zero = (p_s5 == '0);
	end

endmodule
`default_nettype wire

[rtl/core/ssr_ctrl.sv]
`default_nettype none
module ssr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire ssr_pkg::ssr_stat_t stat,
	output ssr_pkg::ssr_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SUM,
		S_DIV,
		S_DIVFIN,
		S_RWAIT,
		S_NINIT,
		S_COARSE,
		S_FINE,
		S_DONE
	} state_t;

	state_t state_q;
	logic [ssr_pkg::LEN_W-1:0] idx_q;
	logic [3:0] v_q;
	logic [ssr_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [1:0] stat_q;
	logic out_valid_q;

	logic accept;
	logic issue;
	logic out_free;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign issue = ((state_q == S_SUM) && (idx_q < stat.len)) ||
		((state_q == S_DECODE) && stat.kind == ssr_pkg::KIND_READ && stat.ready && stat.pos_ok);

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		cmd.sum_addr = idx_q[ssr_pkg::ADDR_W-1:0];
		cmd.addr_pos = (state_q == S_DECODE);
		cmd.div_bit = (div_cnt_q == '0);
		cmd.out_status = stat_q;
		case (state_q)
			S_DECODE: begin
				if (stat.kind == ssr_pkg::KIND_LOAD) begin
					cmd.load = 1'b1;
					cmd.start_sum = stat.last;
				end else if (!stat.ready || !stat.pos_ok) begin
					cmd.res_zero = 1'b1;
				end
			end
			S_SUM: begin
				cmd.acc = v_q[3];
				cmd.div_init = !issue && (v_q == 4'd0);
			end
			S_DIV: cmd.div_step = 1'b1;
			S_DIVFIN: cmd.div_fin = 1'b1;
			S_RWAIT: cmd.pmul = v_q[3];
			S_NINIT: begin
				cmd.norm_init = 1'b1;
				cmd.res_zero = stat.p_zero;
			end
			S_COARSE: cmd.norm_coarse = stat.top_zero;
			S_FINE: cmd.norm_fine = 1'b1;
			S_DONE: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			v_q <= '0;
			div_cnt_q <= '0;
			stat_q <= ssr_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			v_q <= {v_q[2:0], issue};
			if (issue && state_q == S_SUM) idx_q <= idx_q + 1'b1;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (stat.kind == ssr_pkg::KIND_LOAD) begin
						idx_q <= '0;
						state_q <= stat.last ? S_SUM : S_IDLE;
					end else if (!stat.ready) begin
						stat_q <= ssr_pkg::ST_NOT_READY;
						state_q <= S_DONE;
					end else if (!stat.pos_ok) begin
						stat_q <= ssr_pkg::ST_RANGE;
						state_q <= S_DONE;
					end else begin
						stat_q <= stat.ovf ? ssr_pkg::ST_OVERFLOW : ssr_pkg::ST_OK;
						state_q <= S_RWAIT;
					end
				end
				S_SUM: begin
					if (!issue && v_q == 4'd0) begin
						div_cnt_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == ssr_pkg::DIV_CNT_W'(ssr_pkg::DIV_STEPS - 1)) state_q <= S_DIVFIN;
				end
				S_DIVFIN: state_q <= S_IDLE;
				S_RWAIT: begin
					if (v_q[3]) state_q <= S_NINIT;
				end
				S_NINIT: state_q <= stat.p_zero ? S_DONE : S_COARSE;
				S_COARSE: begin
					if (!stat.top_zero) state_q <= S_FINE;
				end
				S_FINE: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/scaled_softmax_row_core.sv]
`default_nettype none
// Softmax over one row of bf16 attention scores, with the scores scaled by 1/16. Each request
// is either a load (kind 0) of one score or a read (kind 1) of the probability at a position;
// loads give no result and reads give exactly one. A load converts the score to Q8.16 as it is
// accepted, then writes it to the score memory and updates the running maximum. The load
// marked last also closes the row: the exponential pipeline streams the stored scores at one
// per cycle for the sum pass, and a bit-serial divider then forms the reciprocal of the sum.
// A read that can be answered at once (row not closed, or position beyond the row) returns a
// zero probability. Any other read goes through the memory port and the exponential pipeline,
// one multiply by the reciprocal, and up to five byte shifts of the normalizer before rounding
// to bf16; when the exponential underflows to zero the normalizer is skipped. One request is
// worked on at a time; the result register lets the next request be accepted while a result
// still waits on the output. The score memory needs no clearing after reset, since only
// entries of the current row are ever read.
module scaled_softmax_row_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [15:0] score_bits,
	input  wire logic        last,
	input  wire logic [11:0] position,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      probability_bits,
	output logic [1:0]       status
);

	// The controller sequences loads, the sum pass, the divider and the conversion;
	// the datapath holds the row state, the memory and the arithmetic.
	ssr_pkg::ssr_cmd_t cmd;
	ssr_pkg::ssr_stat_t stat;

	ssr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssr_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.kind             (kind),
		.score_bits       (score_bits),
		.last             (last),
		.position         (position),
		.cmd              (cmd),
		.stat             (stat),
		.probability_bits (probability_bits),
		.status           (status)
	);

endmodule
`default_nettype wire

[rtl/core/ssr_checker.sv]
`default_nettype none
`include "scaled_softmax_row_core_assert.svh"
module ssr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        kind,
	input wire logic [15:0] score_bits,
	input wire logic        last,
	input wire logic [11:0] position,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] probability_bits,
	input wire logic [1:0]  status
);

	// A stalled result holds.
	`SSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(probability_bits) && $stable(status))
	// Every accepted request leaves the block busy in the cycle after it is accepted.
	`SSR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// Rejected reads carry a zero probability.
	`SSR_ASSERT_SAME(a_error_zero, clk, arst_n, out_valid && (status == ssr_pkg::ST_NOT_READY || status == ssr_pkg::ST_RANGE), probability_bits == 16'h0000)
	// A served probability never exceeds one.
	`SSR_ASSERT_SAME(a_prob_le_one, clk, arst_n, out_valid && (status == ssr_pkg::ST_OK || status == ssr_pkg::ST_OVERFLOW), probability_bits <= 16'h3F80)

endmodule

bind scaled_softmax_row_core ssr_checker u_ssr_checker (.*);
`default_nettype wire
